FILE: hw/rtl/esp_pkg.sv
// Shared constants, codes and interface structs of the encoder speed and position tracker.
package esp_pkg;

	localparam int SCALE_W = 32;
	localparam int FRAC_W  = 16;
	localparam int DIGIT_W = 4;
	localparam int DIGITS  = SCALE_W / DIGIT_W;
	localparam int MAG_W   = 48;
	localparam int POS_W   = 48;
	localparam int DELTA_W = 34;
	localparam int COUNT_W = 16;
	localparam int WRAP_W  = 16;
	localparam int REV_W   = 32;
	localparam int SPEED_W = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

	typedef enum logic [1:0] {
		ACT_WRAP   = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic {
		REG_SPEED_SCALE = 1'b0,
		REG_ANGLE_SCALE = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic               start;
		logic               neg;
		logic [MAG_W-1:0]   mag;
		logic [SCALE_W-1:0] scale;
	} scale_req_t;

	typedef struct packed {
		logic clear;
		logic sub;
		logic add;
	} ring_ctl_t;

endpackage

FILE: hw/rtl/esp_scale.sv
// Digit-serial Q16.16 scaler: floor(sign * mag * scale / 2^16), saturated to 32 bits signed.
module esp_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  esp_pkg::scale_req_t          req,
	output logic                         busy,
	output logic [esp_pkg::SPEED_W-1:0]  result
);

	localparam int CNT_W  = $clog2(esp_pkg::DIGITS + 1);
	localparam int STEP_W = esp_pkg::MAG_W + esp_pkg::DIGIT_W;
	localparam int ACC_LO = esp_pkg::SPEED_W + esp_pkg::FRAC_W - 1 - esp_pkg::SCALE_W;
	localparam logic [esp_pkg::SPEED_W-1:0] SAT_MAX = {1'b0, {(esp_pkg::SPEED_W-1){1'b1}}};
	localparam logic [esp_pkg::SPEED_W-1:0] SAT_MIN = {1'b1, {(esp_pkg::SPEED_W-1){1'b0}}};

	logic                          busy_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          neg_q;
	logic [esp_pkg::MAG_W-1:0]     mag_q;
	logic [esp_pkg::SCALE_W-1:0]   scale_q;
	logic [esp_pkg::MAG_W-1:0]     acc_q;
	logic [esp_pkg::SCALE_W-1:0]   low_q;
	logic [esp_pkg::SPEED_W-1:0]   result_q;

	logic [STEP_W-1:0]             pp;
	logic [STEP_W-1:0]             step_sum;
	logic                          last_step;
	logic                          hi_nz;
	logic                          frac;
	logic [esp_pkg::SPEED_W-2:0]   q_low;
	logic [esp_pkg::SPEED_W-1:0]   q_rnd;
	logic [esp_pkg::SPEED_W-1:0]   res_d;

	assign last_step = (cnt_q == CNT_W'(esp_pkg::DIGITS));

	// One digit of the scale factor per cycle, least significant first.
	always_comb begin
		pp = '0;
		for (int i = 0; i < esp_pkg::DIGIT_W; i++) begin
			if (scale_q[i]) begin
				pp = pp + (STEP_W'(mag_q) << i);
			end
		end
		step_sum = pp + STEP_W'(acc_q);
	end

	// The product is acc_q above low_q; the quotient drops the 16 fraction bits.
	always_comb begin
		hi_nz = |acc_q[esp_pkg::MAG_W-1:ACC_LO];
		q_low = {acc_q[ACC_LO-1:0], low_q[esp_pkg::SCALE_W-1:esp_pkg::FRAC_W]};
		frac  = |low_q[esp_pkg::FRAC_W-1:0];
		q_rnd = {1'b0, q_low} + esp_pkg::SPEED_W'(frac);
		if (!neg_q) begin
			res_d = hi_nz ? SAT_MAX : {1'b0, q_low};
		end else begin
			res_d = hi_nz ? SAT_MIN : (esp_pkg::SPEED_W'(0) - q_rnd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && last_step) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q   <= req.neg;
			mag_q   <= req.mag;
			scale_q <= req.scale;
			acc_q   <= '0;
			low_q   <= '0;
		end else if (busy_q && !last_step) begin
			acc_q   <= step_sum[STEP_W-1:esp_pkg::DIGIT_W];
			low_q   <= {step_sum[esp_pkg::DIGIT_W-1:0],
				low_q[esp_pkg::SCALE_W-1:esp_pkg::DIGIT_W]};
			scale_q <= scale_q >> esp_pkg::DIGIT_W;
		end else if (busy_q) begin
			result_q <= res_d;
		end
	end

	assign busy   = busy_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("scaler started while busy");
`endif

endmodule

FILE: hw/rtl/esp_avg_div.sv
// Bit-serial floor division of the signed ring sum by the ring depth.
module esp_avg_div #(
	parameter int RING_DEPTH = 8
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              start,
	input  logic [esp_pkg::SPEED_W+$clog2(RING_DEPTH)-1:0]    sum,
	output logic                                              busy,
	output logic [esp_pkg::SPEED_W-1:0]                       avg
);

	localparam int SUM_W = esp_pkg::SPEED_W + $clog2(RING_DEPTH);
	localparam int R_W   = $clog2(RING_DEPTH) + 1;
	localparam int CNT_W = $clog2(SUM_W + 1);
	localparam logic [R_W-1:0] DIVISOR = R_W'(RING_DEPTH);

	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        neg_q;
	logic [SUM_W-1:0]            num_q;
	logic [R_W-1:0]              rem_q;
	logic [esp_pkg::SPEED_W-1:0] avg_q;

	logic                        last_step;
	logic [R_W-1:0]              r2;
	logic                        ge;
	logic [esp_pkg::SPEED_W-1:0] q32;
	logic [esp_pkg::SPEED_W-1:0] avg_d;

	assign last_step = (cnt_q == CNT_W'(SUM_W));
	assign r2        = {rem_q[R_W-2:0], num_q[SUM_W-1]};
	assign ge        = (r2 >= DIVISOR);

	// A negative sum with a remainder rounds one further toward minus infinity.
	always_comb begin
		q32   = num_q[esp_pkg::SPEED_W-1:0]
			+ esp_pkg::SPEED_W'(neg_q && (rem_q != '0));
		avg_d = neg_q ? (esp_pkg::SPEED_W'(0) - q32) : q32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && last_step) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= sum[SUM_W-1];
			num_q <= sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
			rem_q <= '0;
		end else if (busy_q && !last_step) begin
			num_q <= {num_q[SUM_W-2:0], ge};
			rem_q <= ge ? (r2 - DIVISOR) : r2;
		end else if (busy_q) begin
			avg_q <= avg_d;
		end
	end

	assign busy = busy_q;
	assign avg  = avg_q;

`ifndef NO_ASSERTIONS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(start) |-> rem_q < DIVISOR)
		else $error("division remainder reached the divisor");
`endif

endmodule

FILE: hw/rtl/esp_ring.sv
// Ring of recent speed values with its running sum and per-entry valid bits.
module esp_ring #(
	parameter int RING_DEPTH = 8
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  esp_pkg::ring_ctl_t                                ctl,
	input  logic [esp_pkg::SPEED_W-1:0]                       wdata,
	output logic [esp_pkg::SPEED_W+$clog2(RING_DEPTH)-1:0]    sum
);

	localparam int SUM_W  = esp_pkg::SPEED_W + $clog2(RING_DEPTH);
	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int EXT_W  = SUM_W - esp_pkg::SPEED_W;

	logic [esp_pkg::SPEED_W-1:0] mem [RING_DEPTH];
	logic [esp_pkg::SPEED_W-1:0] rdata_q;
	logic [RING_DEPTH-1:0]       valid_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [SUM_W-1:0]            sum_q;
	logic [esp_pkg::SPEED_W-1:0] old_val;

	// An entry not written since the last clear counts as zero.
	assign old_val = valid_q[slot_q] ? rdata_q : '0;

	always_ff @(posedge clk) begin
		rdata_q <= mem[slot_q];
		if (ctl.add) begin
			mem[slot_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q  <= '0;
			sum_q   <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
			sum_q   <= '0;
		end else if (ctl.sub) begin
			sum_q <= sum_q - {{EXT_W{old_val[esp_pkg::SPEED_W-1]}}, old_val};
		end else if (ctl.add) begin
			sum_q           <= sum_q + {{EXT_W{wdata[esp_pkg::SPEED_W-1]}}, wdata};
			valid_q[slot_q] <= 1'b1;
			slot_q          <= (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
		end
	end

	assign sum = sum_q;

endmodule

FILE: hw/rtl/encoder_speed_position_tracker.sv
// Encoder speed and position tracker: event sequencer, state registers and result register.
//
//   channel  direction  handshake              payload
//   in       receive    in_valid / in_stall    action, count, count_down
//   out      send       out_valid / out_stall  speed_now, speed_avg, position, angle
//   cfg      receive    cfg_we                 cfg_index, cfg_data
//
// One event at a time. Every event runs the bit-serial average divider, the longest step of
// an event. A speed sample adds the ring update, and a sample that is not the first after a
// clear adds the digit-serial speed scaling.
// Reset clears all tracking state and the ring valid bits at once; no clearing pass is needed.
// A result waiting under out_stall does not block acceptance of the next event; that event
// waits in ST_DONE until the earlier result is taken.
module encoder_speed_position_tracker #(
	parameter int RING_DEPTH      = 8,
	parameter int COUNTS_PER_TURN = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          action,
	input  logic [esp_pkg::COUNT_W-1:0]         count,
	input  logic                                count_down,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [esp_pkg::SPEED_W-1:0]  speed_now,
	output logic signed [esp_pkg::SPEED_W-1:0]  speed_avg,
	output logic signed [esp_pkg::POS_W-1:0]    position,
	output logic signed [esp_pkg::SPEED_W-1:0]  angle,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [esp_pkg::SCALE_W-1:0]         cfg_data
);

	localparam int SUM_W = esp_pkg::SPEED_W + $clog2(RING_DEPTH);
	localparam logic [esp_pkg::REV_W-1:0] REV_MAX = {1'b0, {(esp_pkg::REV_W-1){1'b1}}};
	localparam logic [esp_pkg::REV_W-1:0] REV_MIN = {1'b1, {(esp_pkg::REV_W-1){1'b0}}};
	localparam logic [esp_pkg::WRAP_W-1:0] WRAP_FULL = '1;

	typedef enum logic [8:0] {
		ST_IDLE       = 9'b0_0000_0001,
		ST_PREP       = 9'b0_0000_0010,
		ST_SPEED_GO   = 9'b0_0000_0100,
		ST_SPEED_WAIT = 9'b0_0000_1000,
		ST_RING_SUB   = 9'b0_0001_0000,
		ST_RING_ADD   = 9'b0_0010_0000,
		ST_ANGLE_GO   = 9'b0_0100_0000,
		ST_ANGLE_WAIT = 9'b0_1000_0000,
		ST_DONE       = 9'b1_0000_0000
	} state_t;

	state_t                         state_q;
	esp_pkg::action_t               act_q;
	logic [esp_pkg::COUNT_W-1:0]    count_q;
	logic                           down_q;
	logic [esp_pkg::WRAP_W-1:0]     wrap_q;
	logic [esp_pkg::COUNT_W-1:0]    prev_q;
	logic                           first_q;
	logic [esp_pkg::REV_W-1:0]      rev_q;
	logic [esp_pkg::DELTA_W-1:0]    delta_q;
	logic [esp_pkg::POS_W-1:0]      pos_q;
	logic [esp_pkg::SPEED_W-1:0]    speed_q;
	logic [esp_pkg::SCALE_W-1:0]    speed_scale_q;
	logic [esp_pkg::SCALE_W-1:0]    angle_scale_q;
	logic                           out_valid_q;
	logic [esp_pkg::SPEED_W-1:0]    speed_now_q;
	logic [esp_pkg::SPEED_W-1:0]    speed_avg_q;
	logic [esp_pkg::POS_W-1:0]      position_q;
	logic [esp_pkg::SPEED_W-1:0]    angle_q;

	logic                           in_acc;
	logic                           load_out;
	logic [esp_pkg::DELTA_W-1:0]    wraps;
	logic [esp_pkg::DELTA_W-1:0]    diff;
	logic [esp_pkg::DELTA_W-1:0]    delta_d;
	logic [esp_pkg::DELTA_W-1:0]    delta_mag;
	logic [esp_pkg::POS_W-1:0]      pos_d;
	logic [esp_pkg::POS_W-1:0]      pos_mag;
	esp_pkg::scale_req_t            scale_req;
	logic                           mul_busy;
	logic [esp_pkg::SPEED_W-1:0]    mul_res;
	esp_pkg::ring_ctl_t             ring_ctl;
	logic [SUM_W-1:0]               ring_sum;
	logic                           div_start;
	logic                           div_busy;
	logic [esp_pkg::SPEED_W-1:0]    div_avg;

	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Count change since the last sample, with whole turns added or taken off.
	always_comb begin
		wraps   = esp_pkg::DELTA_W'(wrap_q) * esp_pkg::DELTA_W'(COUNTS_PER_TURN);
		diff    = esp_pkg::DELTA_W'(count_q) - esp_pkg::DELTA_W'(prev_q);
		delta_d = down_q ? (diff - wraps) : (diff + wraps);
		pos_d   = {{(esp_pkg::POS_W-esp_pkg::REV_W){rev_q[esp_pkg::REV_W-1]}}, rev_q}
			* esp_pkg::POS_W'(COUNTS_PER_TURN) + esp_pkg::POS_W'(count_q);
		delta_mag = delta_q[esp_pkg::DELTA_W-1] ? (esp_pkg::DELTA_W'(0) - delta_q) : delta_q;
		pos_mag   = pos_q[esp_pkg::POS_W-1] ? (esp_pkg::POS_W'(0) - pos_q) : pos_q;
	end

	always_comb begin
		scale_req.start = (state_q == ST_SPEED_GO) || (state_q == ST_ANGLE_GO);
		if (state_q == ST_SPEED_GO) begin
			scale_req.neg   = delta_q[esp_pkg::DELTA_W-1];
			scale_req.mag   = esp_pkg::MAG_W'(delta_mag);
			scale_req.scale = speed_scale_q;
		end else begin
			scale_req.neg   = pos_q[esp_pkg::POS_W-1];
			scale_req.mag   = esp_pkg::MAG_W'(pos_mag);
			scale_req.scale = angle_scale_q;
		end
	end

	assign ring_ctl.clear = (state_q == ST_PREP) && (act_q == esp_pkg::ACT_CLEAR);
	assign ring_ctl.sub   = (state_q == ST_RING_SUB);
	assign ring_ctl.add   = (state_q == ST_RING_ADD);
	assign div_start      = (state_q == ST_ANGLE_GO);

	esp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scale_req),
		.busy   (mul_busy),
		.result (mul_res)
	);

	esp_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.wdata  (speed_q),
		.sum    (ring_sum)
	);

	esp_avg_div #(
		.RING_DEPTH (RING_DEPTH)
	) u_avg_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (ring_sum),
		.busy   (div_busy),
		.avg    (div_avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wrap_q        <= '0;
			prev_q        <= '0;
			first_q       <= 1'b1;
			rev_q         <= '0;
			out_valid_q   <= 1'b0;
			speed_scale_q <= esp_pkg::SCALE_RESET;
			angle_scale_q <= esp_pkg::SCALE_RESET;
		end else begin
			if (cfg_we) begin
				case (esp_pkg::reg_index_t'(cfg_index))
					esp_pkg::REG_SPEED_SCALE: speed_scale_q <= cfg_data;
					esp_pkg::REG_ANGLE_SCALE: angle_scale_q <= cfg_data;
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PREP;
						if (esp_pkg::action_t'(action) == esp_pkg::ACT_WRAP) begin
							if (wrap_q != WRAP_FULL) begin
								wrap_q <= wrap_q + esp_pkg::WRAP_W'(1);
							end
							// The revolution count restarts at zero from either extreme.
							if (rev_q == REV_MAX || rev_q == REV_MIN) begin
								rev_q <= '0;
							end else if (count_down) begin
								rev_q <= rev_q - esp_pkg::REV_W'(1);
							end else begin
								rev_q <= rev_q + esp_pkg::REV_W'(1);
							end
						end
					end
				end
				ST_PREP: begin
					case (act_q)
						esp_pkg::ACT_SAMPLE: begin
							wrap_q  <= '0;
							prev_q  <= count_q;
							first_q <= 1'b0;
							state_q <= first_q ? ST_RING_SUB : ST_SPEED_GO;
						end
						esp_pkg::ACT_CLEAR: begin
							first_q <= 1'b1;
							state_q <= ST_ANGLE_GO;
						end
						default: state_q <= ST_ANGLE_GO;
					endcase
				end
				ST_SPEED_GO: state_q <= ST_SPEED_WAIT;
				ST_SPEED_WAIT: begin
					if (!mul_busy) begin
						state_q <= ST_RING_SUB;
					end
				end
				ST_RING_SUB: state_q <= ST_RING_ADD;
				ST_RING_ADD: state_q <= ST_ANGLE_GO;
				ST_ANGLE_GO: state_q <= ST_ANGLE_WAIT;
				ST_ANGLE_WAIT: begin
					if (!mul_busy && !div_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q   <= esp_pkg::action_t'(action);
			count_q <= count;
			down_q  <= count_down;
		end
		if (state_q == ST_PREP) begin
			delta_q <= delta_d;
			pos_q   <= pos_d;
			speed_q <= '0;
		end
		if (state_q == ST_SPEED_WAIT && !mul_busy) begin
			speed_q <= mul_res;
		end
		if (load_out) begin
			speed_now_q <= speed_q;
			speed_avg_q <= div_avg;
			position_q  <= pos_q;
			angle_q     <= mul_res;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign speed_now = $signed(speed_now_q);
	assign speed_avg = $signed(speed_avg_q);
	assign position  = $signed(position_q);
	assign angle     = $signed(angle_q);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer not busy after an accepted transaction");

	a_units_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !mul_busy && !div_busy)
		else $error("result loaded while an arithmetic unit is busy");

	a_ring_write_sample: assert property (@(posedge clk) disable iff (!arst_n)
		ring_ctl.add |-> act_q == esp_pkg::ACT_SAMPLE)
		else $error("ring written by an event that is not a speed sample");
`endif

endmodule
